/* rtl/esh_pkg.sv */
// ----------------------------------------------------------------------------
// esh_pkg
// Shared types, constants and helpers of the entropy sample health check.
// ----------------------------------------------------------------------------
`default_nettype none

package esh_pkg;

  // fixed field widths
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned MIN_DIST_W   = 4;

  // parameter defaults
  localparam int unsigned DISTINCT_CAP_DEF = 8;
  localparam int unsigned VALUE_BITS_DEF   = 14;

  // register reset values
  localparam logic [COUNT_W-1:0]    MIN_SAMPLES_RST  = 16'd16;
  localparam logic [COUNT_W-1:0]    RUN_LIMIT_RST    = 16'd32;
  localparam logic [MIN_DIST_W-1:0] MIN_DISTINCT_RST = 4'd5;

  // saturation limit of the counters
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTINCT = 2'd2;

  // transaction function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } esh_state_e;

  // saturating increment of a counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/entropy_sample_health_check.sv */
// Entropy sample health check. A sample transaction (func 0) takes the low
// VALUE_BITS bits of a timing delta and folds them into the window statistics;
// a finish transaction (func 1) delivers sample count, distinct count, longest
// repeat run, min, max and a pass verdict, then clears the window. The block
// handles one transaction at a time. Run, min and max update in the accept
// cycle, then a single equality comparator walks the stored distinct values
// one entry per cycle until a hit or the end of the stored entries, where a
// new value is stored; once the table is full no walk is made. A finish
// fills the result register and clears the window, and the
// next transaction waits until the result register has been taken. Register
// writes take effect at once and are meant to be issued while the block is
// idle.
// ----------------------------------------------------------------------------
// entropy_sample_health_check
// Window statistics and pass verdict on low bits of noise source deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module entropy_sample_health_check #(
  parameter int unsigned DISTINCT_CAP = esh_pkg::DISTINCT_CAP_DEF,
  parameter int unsigned VALUE_BITS   = esh_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration port
  input  wire logic                                 cfg_we_i,
  input  wire logic [esh_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [esh_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 func_i,
  input  wire logic [31:0]                          delta_i,
  // output channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [esh_pkg::COUNT_W-1:0]               sample_count_o,
  output logic [$clog2(DISTINCT_CAP+1)-1:0]         distinct_count_o,
  output logic [esh_pkg::COUNT_W-1:0]               longest_run_o,
  output logic [VALUE_BITS-1:0]                     min_value_o,
  output logic [VALUE_BITS-1:0]                     max_value_o,
  output logic                                      pass_o
);

  import esh_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DISTINCT_CAP + 1);
  localparam int unsigned IDX_W  = $clog2(DISTINCT_CAP);
  localparam int unsigned CMP_W  = (CNT_W > MIN_DIST_W) ? CNT_W : MIN_DIST_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(DISTINCT_CAP);

  // configuration registers
  logic [COUNT_W-1:0]    min_samples_q;
  logic [COUNT_W-1:0]    run_limit_q;
  logic [MIN_DIST_W-1:0] min_distinct_q;

  // window state
  esh_state_e            state_q, state_d;
  logic [VALUE_BITS-1:0] prev_value_q;
  logic [COUNT_W-1:0]    samples_seen_q;
  logic [COUNT_W-1:0]    current_run_q;
  logic [COUNT_W-1:0]    best_run_q;
  logic [CNT_W-1:0]      seen_count_q;
  logic [VALUE_BITS-1:0] low_mark_q;
  logic [VALUE_BITS-1:0] high_mark_q;
  logic [VALUE_BITS-1:0] seen_values_q [DISTINCT_CAP];

  // scan state
  logic [VALUE_BITS-1:0] scan_value_q;
  logic [CNT_W-1:0]      scan_idx_q;

  // result register
  logic                  out_valid_q;
  logic [COUNT_W-1:0]    res_samples_q;
  logic [CNT_W-1:0]      res_distinct_q;
  logic [COUNT_W-1:0]    res_run_q;
  logic [VALUE_BITS-1:0] res_min_q;
  logic [VALUE_BITS-1:0] res_max_q;
  logic                  res_pass_q;

  // handshakes
  logic in_acc;
  logic out_acc;
  logic sample_acc;
  logic finish_acc;

  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign sample_acc = in_acc && (func_i == FUNC_SAMPLE);
  assign finish_acc = in_acc && (func_i == FUNC_FINISH);

  // sample value and run tracking
  logic [VALUE_BITS-1:0] sample_v;
  logic                  repeat_hit;
  logic [COUNT_W-1:0]    run_next;

  assign sample_v   = delta_i[VALUE_BITS-1:0];
  assign repeat_hit = (samples_seen_q != '0) && (sample_v == prev_value_q);
  assign run_next   = repeat_hit ? sat_inc(current_run_q) : COUNT_W'(1);

  // shared comparator over the stored distinct values
  logic             cap_full;
  logic             scan_end;
  logic             scan_hit;
  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] wr_addr;

  assign cap_full  = (seen_count_q == CAP_CNT);
  assign scan_end  = (scan_idx_q == seen_count_q);
  assign scan_addr = scan_idx_q[IDX_W-1:0];
  assign wr_addr   = seen_count_q[IDX_W-1:0];
  assign scan_hit  = !scan_end && (seen_values_q[scan_addr] == scan_value_q);

  // pass verdict
  logic win_pass;

  assign win_pass = (samples_seen_q >= min_samples_q) && (best_run_q < run_limit_q) &&
                    (CMP_W'(seen_count_q) >= CMP_W'(min_distinct_q));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sample_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cap_full || scan_end || scan_hit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q  <= MIN_SAMPLES_RST;
      run_limit_q    <= RUN_LIMIT_RST;
      min_distinct_q <= MIN_DISTINCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_SAMPLES:  min_samples_q  <= cfg_wdata_i;
        CFG_RUN_LIMIT:    run_limit_q    <= cfg_wdata_i;
        CFG_MIN_DISTINCT: min_distinct_q <= cfg_wdata_i[MIN_DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // window statistics and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      prev_value_q   <= '0;
      samples_seen_q <= '0;
      current_run_q  <= '0;
      best_run_q     <= '0;
      seen_count_q   <= '0;
      low_mark_q     <= '1;
      high_mark_q    <= '0;
      scan_idx_q     <= '0;
    end else begin
      state_q <= state_d;
      if (finish_acc) begin
        prev_value_q   <= '0;
        samples_seen_q <= '0;
        current_run_q  <= '0;
        best_run_q     <= '0;
        seen_count_q   <= '0;
        low_mark_q     <= '1;
        high_mark_q    <= '0;
      end else if (sample_acc) begin
        prev_value_q   <= sample_v;
        samples_seen_q <= sat_inc(samples_seen_q);
        current_run_q  <= run_next;
        if (repeat_hit && (run_next > best_run_q)) begin
          best_run_q <= run_next;
        end
        if (sample_v < low_mark_q) begin
          low_mark_q <= sample_v;
        end
        if (sample_v > high_mark_q) begin
          high_mark_q <= sample_v;
        end
        scan_idx_q <= '0;
      end else if (state_q == ST_SCAN) begin
        if (!cap_full && scan_end) begin
          seen_count_q <= seen_count_q + 1'b1;
        end else if (!cap_full && !scan_hit) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
      end
    end
  end

  // scan operand
  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      scan_value_q <= sample_v;
    end
  end

  // distinct value table
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && !cap_full && scan_end) begin
      seen_values_q[wr_addr] <= scan_value_q;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (finish_acc) begin
      res_samples_q  <= samples_seen_q;
      res_distinct_q <= seen_count_q;
      res_run_q      <= best_run_q;
      res_min_q      <= (samples_seen_q != '0) ? low_mark_q : '0;
      res_max_q      <= (samples_seen_q != '0) ? high_mark_q : '0;
      res_pass_q     <= win_pass;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_count_o   = res_samples_q;
  assign distinct_count_o = res_distinct_q;
  assign longest_run_o    = res_run_q;
  assign min_value_o      = res_min_q;
  assign max_value_o      = res_max_q;
  assign pass_o           = res_pass_q;

`ifndef SYNTHESIS
  // distinct count never passes the cap
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_count_q <= CAP_CNT)
    else $error("distinct count above cap");

  // scan pointer stays within the stored entries
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_idx_q <= seen_count_q))
    else $error("scan pointer past stored entries");

  // finish produces a result and clears the window
  a_finish_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_acc |=> (out_valid_q && (samples_seen_q == '0) && (seen_count_q == '0)))
    else $error("finish did not report and clear");

  // a running repeat is always reflected in the best run
  a_best_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (current_run_q > COUNT_W'(1)) |-> (best_run_q >= current_run_q))
    else $error("best run below current run");

  // min and max are ordered once a sample is seen
  a_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (samples_seen_q != '0) |-> (low_mark_q <= high_mark_q))
    else $error("low mark above high mark");
`endif

endmodule

`default_nettype wire
